>>> sv/imhtq_pkg.sv
// Shared types, codes and default sizes for the indexed min-heap timer queue.
// No dependencies; every other file of the block imports this package.
package imhtq_pkg;

    localparam int NUM_TIMERS_DEF    = 32;
    localparam int TIME_BITS_DEF     = 64;
    localparam int MAX_CALLBACKS_DEF = 255;

    localparam int ID_W       = 5;
    localparam int CMD_W      = 2;
    localparam int CNT_OUT_W  = 8;
    localparam int PORT_T_W   = 64;
    localparam int RESULT_CAP = 32;
    localparam int RIDX_W     = $clog2(RESULT_CAP);
    localparam int RCNT_W     = $clog2(RESULT_CAP + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_EXPIRE = 2'd2
    } t_cmd;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_ENQ0, S_ENQ1,
        S_CAN0, S_CAN1,
        S_TAKE0, S_TAKE1,
        S_UP0, S_UP1,
        S_DN0, S_DN1, S_DN2, S_DN3,
        S_XP0, S_XP1, S_XP2, S_XEND,
        S_FIN0, S_FIN1
    } t_state;

    typedef struct packed {
        logic                 item_valid;
        logic [ID_W-1:0]      fired_id;
        logic [CNT_OUT_W-1:0] callback_count;
        logic                 new_earliest;
        logic                 status;
    } t_rec;

    typedef struct packed {
        logic              go;
        logic [RIDX_W-1:0] lastk;
        logic              e_valid;
    } t_emit;

endpackage

>>> sv/imhtq_rbuf.sv
// Result buffer: holds the result records of one transaction and plays them out
// one per cycle with the final earliest fields. Depends on imhtq_pkg.
module imhtq_rbuf #(
    parameter int TIME_BITS = imhtq_pkg::TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [imhtq_pkg::RIDX_W-1:0] i_widx,
    input  imhtq_pkg::t_rec       i_rec,
    input  imhtq_pkg::t_emit      i_emit,
    input  logic [TIME_BITS-1:0]  i_edl,
    output logic                  o_busy,
    output logic                  o_strobe,
    output logic                  o_last,
    output imhtq_pkg::t_rec       o_rec,
    output logic                  o_evalid,
    output logic [TIME_BITS-1:0]  o_edl
);
    import imhtq_pkg::*;

    t_rec              r_mem [RESULT_CAP];
    t_rec              r_rd;
    logic              r_act;
    logic [RIDX_W-1:0] r_k;
    logic [RIDX_W-1:0] r_lastk;
    logic              r_sv;
    logic              r_sl;
    logic              r_ev;
    logic [TIME_BITS-1:0] r_edl;

    // Store records and read the current play-out slot
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_widx] <= i_rec;
        end
        r_rd <= r_mem[r_k];
    end

    // Sequence the play-out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_sv  <= 1'b0;
            r_sl  <= 1'b0;
            r_k   <= '0;
        end else begin
            r_sv <= r_act;
            r_sl <= r_act && (r_k == r_lastk);
            if (i_emit.go) begin
                r_act   <= 1'b1;
                r_k     <= '0;
                r_lastk <= i_emit.lastk;
                r_ev    <= i_emit.e_valid;
                r_edl   <= i_edl;
            end else if (r_act) begin
                r_k <= r_k + 1'b1;
                if (r_k == r_lastk) begin
                    r_act <= 1'b0;
                end
            end
        end
    end

    assign o_busy   = r_act;
    assign o_strobe = r_sv;
    assign o_last   = r_sl;
    assign o_rec    = r_rd;
    assign o_evalid = r_ev;
    assign o_edl    = r_edl;

endmodule

>>> sv/imhtq_engine.sv
// Heap engine: heap, position and callback-count memories with the sequencer
// that inserts, removes and pops entries one memory access per step.
// Depends on imhtq_pkg.
module imhtq_engine #(
    parameter int NUM_TIMERS    = imhtq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS     = imhtq_pkg::TIME_BITS_DEF,
    parameter int MAX_CALLBACKS = imhtq_pkg::MAX_CALLBACKS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [imhtq_pkg::CMD_W-1:0]  i_cmd,
    input  logic [imhtq_pkg::ID_W-1:0]   i_timer_id,
    input  logic [TIME_BITS-1:0]         i_deadline,
    input  logic [TIME_BITS-1:0]         i_now,
    output logic                         o_idle,
    output logic                         o_rec_we,
    output logic [imhtq_pkg::RIDX_W-1:0] o_rec_idx,
    output imhtq_pkg::t_rec              o_rec,
    output imhtq_pkg::t_emit             o_emit,
    output logic [TIME_BITS-1:0]         o_edl
);
    import imhtq_pkg::*;

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int SW = $clog2(NUM_TIMERS + 1);
    localparam int LW = IW + 2;
    localparam int CW = $clog2(MAX_CALLBACKS + 1);

    // Memories
    logic [TIME_BITS-1:0] r_hdl  [NUM_TIMERS];
    logic [ID_W-1:0]      r_hown [NUM_TIMERS];
    logic [IW-1:0]        r_pos  [NUM_TIMERS];
    logic [CW-1:0]        r_cnt  [NUM_TIMERS];

    logic [TIME_BITS-1:0] h_rd_dl;
    logic [ID_W-1:0]      h_rd_own;
    logic [IW-1:0]        p_rd;
    logic [CW-1:0]        c_rd;

    logic                 h_we, p_we, c_we;
    logic [IW-1:0]        h_ra, h_wa, p_ra, p_wa, c_ra, c_wa;
    logic [TIME_BITS-1:0] h_wdl;
    logic [ID_W-1:0]      h_wown;
    logic [IW-1:0]        p_wd;
    logic [CW-1:0]        c_wd;

    // Control and working registers
    t_state               r_st, n_st;
    t_cmd                 r_cmd, n_cmd;
    logic [ID_W-1:0]      r_id, n_id;
    logic [TIME_BITS-1:0] r_dl, n_dl;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [SW-1:0]        r_size, n_size;
    logic [IW-1:0]        r_i, n_i;
    logic [IW-1:0]        r_l, n_l;
    logic [IW-1:0]        r_cidx, n_cidx;
    logic [TIME_BITS-1:0] r_mdl, n_mdl;
    logic [ID_W-1:0]      r_mown, n_mown;
    logic [TIME_BITS-1:0] r_cdl, n_cdl;
    logic [ID_W-1:0]      r_cown, n_cown;
    logic                 r_tk, n_tk;
    logic [RCNT_W-1:0]    r_n, n_n;
    logic [IW-1:0]        r_clr, n_clr;

    logic                 ok_id;
    logic [IW-1:0]        hid;
    logic [IW-1:0]        parent;
    logic [IW-1:0]        lastidx;
    logic [LW-1:0]        left, size_x;
    t_state               post_st;

    // Heap memory: deadline and owner share one address
    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hdl[h_wa]  <= h_wdl;
            r_hown[h_wa] <= h_wown;
        end
        h_rd_dl  <= r_hdl[h_ra];
        h_rd_own <= r_hown[h_ra];
    end

    // Position memory
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pos[p_wa] <= p_wd;
        end
        p_rd <= r_pos[p_ra];
    end

    // Callback-count memory
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cnt[c_wa] <= c_wd;
        end
        c_rd <= r_cnt[c_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_CLR;
            r_clr  <= '0;
            r_size <= '0;
            r_n    <= '0;
            r_tk   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_clr  <= n_clr;
            r_size <= n_size;
            r_n    <= n_n;
            r_tk   <= n_tk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_id   <= n_id;
        r_dl   <= n_dl;
        r_now  <= n_now;
        r_i    <= n_i;
        r_l    <= n_l;
        r_cidx <= n_cidx;
        r_mdl  <= n_mdl;
        r_mown <= n_mown;
        r_cdl  <= n_cdl;
        r_cown <= n_cown;
    end

    assign ok_id   = 32'(r_id) < 32'(NUM_TIMERS);
    assign hid     = IW'(r_id);
    assign parent  = IW'((r_i - 1'b1) >> 1);
    assign lastidx = IW'(r_size - 1'b1);
    assign left    = (LW'(r_i) << 1) + LW'(1);
    assign size_x  = LW'(r_size);
    assign post_st = (r_cmd == CMD_EXPIRE) ? S_XP0 : S_FIN0;

    // Sequence one transaction
    always_comb begin
        n_st = r_st;   n_cmd = r_cmd;   n_id = r_id;     n_dl = r_dl;
        n_now = r_now; n_size = r_size; n_i = r_i;       n_l = r_l;
        n_cidx = r_cidx; n_mdl = r_mdl; n_mown = r_mown; n_cdl = r_cdl;
        n_cown = r_cown; n_tk = r_tk;   n_n = r_n;       n_clr = r_clr;
        h_we = 1'b0; h_wa = r_i; h_wdl = r_mdl; h_wown = r_mown; h_ra = '0;
        p_we = 1'b0; p_wa = IW'(r_mown); p_wd = r_i; p_ra = hid;
        c_we = 1'b0; c_wa = hid; c_wd = '0; c_ra = hid;
        o_rec_we = 1'b0;
        o_rec    = '0;
        o_emit   = '0;
        unique case (r_st)
            S_CLR: begin
                c_we  = 1'b1;
                c_wa  = r_clr;
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == 32'(NUM_TIMERS - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = t_cmd'(i_cmd);
                    n_id  = i_timer_id;
                    n_dl  = i_deadline;
                    n_now = i_now;
                    n_n   = '0;
                    priority case (t_cmd'(i_cmd))
                        CMD_ENQ:    n_st = S_ENQ0;
                        CMD_CANCEL: n_st = S_CAN0;
                        CMD_EXPIRE: n_st = S_XP0;
                        default:    n_st = S_XEND;
                    endcase
                end
            end
            S_ENQ0: begin
                if (ok_id) begin
                    n_st = S_ENQ1;
                end else begin
                    o_rec_we = 1'b1;
                    n_n  = r_n + 1'b1;
                    n_st = S_FIN0;
                end
            end
            S_ENQ1: begin
                if (c_rd == '0) begin
                    // insert at the tail and sift up
                    n_mdl  = r_dl;
                    n_mown = r_id;
                    n_i    = IW'(r_size);
                    n_size = r_size + 1'b1;
                    n_tk   = 1'b0;
                    n_st   = S_UP0;
                end else begin
                    o_rec_we = 1'b1;
                    n_n  = r_n + 1'b1;
                    n_st = S_FIN0;
                    if (c_rd < CW'(MAX_CALLBACKS)) begin
                        c_we = 1'b1;
                        c_wd = c_rd + 1'b1;
                    end else begin
                        o_rec.status = 1'b1;
                    end
                end
            end
            S_CAN0: begin
                if (ok_id) begin
                    n_st = S_CAN1;
                end else begin
                    o_rec.fired_id = r_id;
                    o_rec_we = 1'b1;
                    n_n  = r_n + 1'b1;
                    n_st = S_FIN0;
                end
            end
            S_CAN1: begin
                o_rec.fired_id = r_id;
                o_rec_we = 1'b1;
                n_n = r_n + 1'b1;
                if (c_rd == '0) begin
                    n_st = S_FIN0;
                end else begin
                    o_rec.item_valid     = 1'b1;
                    o_rec.callback_count = CNT_OUT_W'(c_rd);
                    c_we = 1'b1;
                    n_i  = p_rd;
                    n_st = S_TAKE0;
                end
            end
            S_TAKE0: begin
                // remove entry r_i; refill the hole from the tail
                h_ra   = lastidx;
                n_size = r_size - 1'b1;
                n_st   = (r_i == lastidx) ? post_st : S_TAKE1;
            end
            S_TAKE1: begin
                n_mdl  = h_rd_dl;
                n_mown = h_rd_own;
                n_tk   = 1'b1;
                n_st   = S_UP0;
            end
            S_UP0: begin
                h_ra = parent;
                if (r_i != '0) begin
                    n_st = S_UP1;
                end else if (r_tk) begin
                    n_tk = 1'b0;
                    n_st = S_DN0;
                end else begin
                    h_we = 1'b1;
                    p_we = 1'b1;
                    n_st = post_st;
                end
            end
            S_UP1: begin
                if (r_mdl < h_rd_dl) begin
                    // move the parent down into the hole
                    h_we   = 1'b1;
                    h_wdl  = h_rd_dl;
                    h_wown = h_rd_own;
                    p_we   = 1'b1;
                    p_wa   = IW'(h_rd_own);
                    n_i    = parent;
                    n_tk   = 1'b0;
                    n_st   = S_UP0;
                end else if (r_tk) begin
                    n_tk = 1'b0;
                    n_st = S_DN0;
                end else begin
                    h_we = 1'b1;
                    p_we = 1'b1;
                    n_st = post_st;
                end
            end
            S_DN0: begin
                h_ra = IW'(left);
                n_l  = IW'(left);
                if (left < size_x) begin
                    n_st = S_DN1;
                end else begin
                    h_we = 1'b1;
                    p_we = 1'b1;
                    n_st = post_st;
                end
            end
            S_DN1: begin
                n_cdl  = h_rd_dl;
                n_cown = h_rd_own;
                n_cidx = r_l;
                h_ra   = r_l + 1'b1;
                n_st   = ((LW'(r_l) + LW'(1)) < size_x) ? S_DN2 : S_DN3;
            end
            S_DN2: begin
                if (!(r_cdl < h_rd_dl)) begin
                    n_cdl  = h_rd_dl;
                    n_cown = h_rd_own;
                    n_cidx = r_l + 1'b1;
                end
                n_st = S_DN3;
            end
            S_DN3: begin
                if (r_mdl < r_cdl) begin
                    h_we = 1'b1;
                    p_we = 1'b1;
                    n_st = post_st;
                end else begin
                    // move the child up into the hole
                    h_we   = 1'b1;
                    h_wdl  = r_cdl;
                    h_wown = r_cown;
                    p_we   = 1'b1;
                    p_wa   = IW'(r_cown);
                    n_i    = r_cidx;
                    n_st   = S_DN0;
                end
            end
            S_XP0: begin
                h_ra = '0;
                n_st = (r_size == '0 || r_n == RCNT_W'(RESULT_CAP)) ? S_XEND : S_XP1;
            end
            S_XP1: begin
                n_mown = h_rd_own;
                c_ra   = IW'(h_rd_own);
                n_st   = (h_rd_dl > r_now) ? S_XEND : S_XP2;
            end
            S_XP2: begin
                o_rec.item_valid     = 1'b1;
                o_rec.fired_id       = r_mown;
                o_rec.callback_count = CNT_OUT_W'(c_rd);
                o_rec_we = 1'b1;
                n_n  = r_n + 1'b1;
                c_we = 1'b1;
                c_wa = IW'(r_mown);
                n_i  = '0;
                n_st = S_TAKE0;
            end
            S_XEND: begin
                if (r_n == '0) begin
                    o_rec_we = 1'b1;
                    n_n = r_n + 1'b1;
                end
                n_st = S_FIN0;
            end
            S_FIN0: begin
                h_ra = '0;
                n_st = S_FIN1;
            end
            S_FIN1: begin
                o_emit.go      = 1'b1;
                o_emit.lastk   = RIDX_W'(r_n - 1'b1);
                o_emit.e_valid = (r_size != '0);
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        // a newly inserted handle gets its first callback once placed
        if (h_we && p_we && (r_cmd == CMD_ENQ) && (p_wa == IW'(r_mown))
                && (r_st != S_UP1 || !(r_mdl < h_rd_dl))
                && (r_st != S_DN3 || (r_mdl < r_cdl))) begin
            c_we = 1'b1;
            c_wa = hid;
            c_wd = CW'(1);
            o_rec_we = 1'b1;
            o_rec.new_earliest = (r_i == '0);
            n_n = r_n + 1'b1;
        end
    end

    assign o_idle    = (r_st == S_IDLE);
    assign o_rec_idx = RIDX_W'(r_n);
    assign o_edl     = (r_size != '0) ? h_rd_dl : '0;

endmodule

>>> sv/indexed_min_heap_timer_queue.sv
// Top level of the indexed min-heap timer queue: engine plus result buffer.
// Depends on imhtq_pkg, imhtq_engine and imhtq_rbuf.
//
// A command is taken when start is high and busy is low. Every command returns
// one or more results, each shown for exactly one cycle with o_strobe high; the
// receiver cannot stall them, and o_last marks the final result of a command.
// All results of a command carry the earliest deadline left after the whole
// command. The time for enqueue and cancel grows with the number of heap levels
// an entry moves (up to log2 NUM_TIMERS): the heap memory gives one read per
// cycle, so a sift-up level costs a read and a compare, and a sift-down level
// two reads, a compare and a write-back. Expire takes out the popped timers like
// cancel, up to 32 pops. Results play out at one per cycle after the heap work
// ends. After reset the block clears its callback counts, busy high.
module indexed_min_heap_timer_queue #(
    parameter int NUM_TIMERS    = imhtq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS     = imhtq_pkg::TIME_BITS_DEF,
    parameter int MAX_CALLBACKS = imhtq_pkg::MAX_CALLBACKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [imhtq_pkg::CMD_W-1:0]         i_cmd,
    input  logic [imhtq_pkg::ID_W-1:0]          i_timer_id,
    input  logic [imhtq_pkg::PORT_T_W-1:0]      i_deadline,
    input  logic [imhtq_pkg::PORT_T_W-1:0]      i_now,
    output logic                                o_strobe,
    output logic                                o_item_valid,
    output logic [imhtq_pkg::ID_W-1:0]          o_fired_id,
    output logic [imhtq_pkg::CNT_OUT_W-1:0]     o_callback_count,
    output logic                                o_new_earliest,
    output logic                                o_earliest_valid,
    output logic [imhtq_pkg::PORT_T_W-1:0]      o_earliest_deadline,
    output logic                                o_status,
    output logic                                o_last
);
    import imhtq_pkg::*;

    logic                 eng_idle;
    logic                 rb_busy;
    logic                 rec_we;
    logic [RIDX_W-1:0]    rec_idx;
    t_rec                 rec;
    t_rec                 out_rec;
    t_emit                emit;
    logic [TIME_BITS-1:0] edl;
    logic [TIME_BITS-1:0] out_edl;

    // Accept a transaction only when both parts are free
    assign busy = !eng_idle || rb_busy;

    imhtq_engine #(
        .NUM_TIMERS    (NUM_TIMERS),
        .TIME_BITS     (TIME_BITS),
        .MAX_CALLBACKS (MAX_CALLBACKS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start && !busy),
        .i_cmd      (i_cmd),
        .i_timer_id (i_timer_id),
        .i_deadline (i_deadline[TIME_BITS-1:0]),
        .i_now      (i_now[TIME_BITS-1:0]),
        .o_idle     (eng_idle),
        .o_rec_we   (rec_we),
        .o_rec_idx  (rec_idx),
        .o_rec      (rec),
        .o_emit     (emit),
        .o_edl      (edl)
    );

    imhtq_rbuf #(
        .TIME_BITS (TIME_BITS)
    ) u_rbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (rec_we),
        .i_widx   (rec_idx),
        .i_rec    (rec),
        .i_emit   (emit),
        .i_edl    (edl),
        .o_busy   (rb_busy),
        .o_strobe (o_strobe),
        .o_last   (o_last),
        .o_rec    (out_rec),
        .o_evalid (o_earliest_valid),
        .o_edl    (out_edl)
    );

    assign o_item_valid        = out_rec.item_valid;
    assign o_fired_id          = out_rec.fired_id;
    assign o_callback_count    = out_rec.callback_count;
    assign o_new_earliest      = out_rec.new_earliest;
    assign o_status            = out_rec.status;
    assign o_earliest_deadline = PORT_T_W'(out_edl);

endmodule

>>> bench/tb_indexed_min_heap_timer_queue.sv
// Testbench for the indexed min-heap timer queue: a queued command driver, a result
// monitor and a heap predictor of its own. Depends on imhtq_pkg and the block's RTL.
module tb_indexed_min_heap_timer_queue;
    import imhtq_pkg::*;

    localparam int NT = 32;
    localparam int MAXCB = 255;
    localparam int CMD_UNUSED = 3;

    typedef struct {
        logic [1:0]  cmd;
        logic [4:0]  id;
        logic [63:0] dl;
        logic [63:0] now;
        bit          hold;
    } t_txn;

    typedef struct {
        logic        item_valid;
        logic [4:0]  fired_id;
        logic [7:0]  cnt;
        logic        new_earliest;
        logic        e_valid;
        logic [63:0] e_dl;
        logic        status;
        logic        last;
    } t_res;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_cmd = 0;
    logic [4:0]  i_timer_id = 0;
    logic [63:0] i_deadline = 0;
    logic [63:0] i_now = 0;
    logic        o_strobe, o_item_valid, o_new_earliest, o_earliest_valid, o_status, o_last;
    logic [4:0]  o_fired_id;
    logic [7:0]  o_callback_count;
    logic [63:0] o_earliest_deadline;

    t_txn pending_cmds[$];
    t_res expected_results[$];
    int   errors = 0;
    bit   stim_done = 0;

    // Predictor state
    logic [63:0] hp_dl[NT];
    int          hp_own[NT];
    int          hp_size = 0;
    int          pos_of[NT];
    int          cb_cnt[NT];

    indexed_min_heap_timer_queue dut (.*);

    // Generate clock
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic void heap_swap(int a, int b);
        logic [63:0] d;
        int o;
        d = hp_dl[a]; o = hp_own[a];
        hp_dl[a] = hp_dl[b]; hp_own[a] = hp_own[b];
        hp_dl[b] = d; hp_own[b] = o;
        pos_of[hp_own[a]] = a;
        pos_of[hp_own[b]] = b;
    endfunction

    function automatic void heap_up(int i);
        while (i > 0 && hp_dl[i] < hp_dl[(i-1)/2]) begin
            heap_swap(i, (i-1)/2);
            i = (i-1)/2;
        end
    endfunction

    function automatic void heap_down(int i);
        int l, c;
        l = 2*i+1;
        while (l < hp_size) begin
            c = (l+1 == hp_size || hp_dl[l] < hp_dl[l+1]) ? l : l+1;
            if (hp_dl[i] < hp_dl[c]) break;
            heap_swap(i, c);
            i = c;
            l = 2*i+1;
        end
    endfunction

    function automatic void heap_remove(int i);
        int lst;
        lst = hp_size - 1;
        if (i != lst) heap_swap(i, lst);
        pos_of[hp_own[lst]] = NT;
        hp_size = lst;
        if (i != lst) begin
            if (i > 0 && hp_dl[i] < hp_dl[(i-1)/2]) heap_up(i);
            else heap_down(i);
        end
    endfunction

    // Work out the results of one accepted transaction and queue them
    function automatic void predict_timer_cmd(t_txn t);
        t_res r[$];
        t_res x;
        x = '{default: 0};
        if (t.cmd == CMD_ENQ) begin
            if (pos_of[t.id] >= hp_size) begin
                hp_dl[hp_size] = t.dl;
                hp_own[hp_size] = t.id;
                pos_of[t.id] = hp_size;
                hp_size++;
                heap_up(hp_size - 1);
            end
            if (cb_cnt[t.id] < MAXCB) begin
                cb_cnt[t.id]++;
                x.new_earliest = (pos_of[t.id] == 0 && cb_cnt[t.id] == 1);
            end else
                x.status = 1;
            r = {r, x};
        end else if (t.cmd == CMD_CANCEL) begin
            x.fired_id = t.id;
            if (pos_of[t.id] < hp_size) begin
                x.item_valid = 1;
                x.cnt = 8'(cb_cnt[t.id]);
                cb_cnt[t.id] = 0;
                heap_remove(pos_of[t.id]);
            end
            r = {r, x};
        end else if (t.cmd == CMD_EXPIRE) begin
            while (hp_size > 0 && r.size() < RESULT_CAP && hp_dl[0] <= t.now) begin
                x = '{default: 0};
                x.item_valid = 1;
                x.fired_id = 5'(hp_own[0]);
                x.cnt = 8'(cb_cnt[hp_own[0]]);
                cb_cnt[hp_own[0]] = 0;
                heap_remove(0);
                r = {r, x};
            end
            if (r.size() == 0) r = {r, x};
        end else
            r = {r, x};
        foreach (r[k]) begin
            r[k].e_valid = hp_size > 0;
            r[k].e_dl = hp_size > 0 ? hp_dl[0] : 64'd0;
            r[k].last = (k == r.size() - 1);
            expected_results = {expected_results, r[k]};
        end
    endfunction

    // Driver: hold start until accepted, then wait a random gap or a result drain
    int gap = 0;
    bit waiting_drain = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_timer_cmd('{i_cmd, i_timer_id, i_deadline, i_now, 0});
                start <= 0;
                gap <= $urandom_range(0, 5);
            end else if (!start) begin
                if (waiting_drain) begin
                    if (expected_results.size() == 0) waiting_drain <= 0;
                end else if (gap > 0)
                    gap <= gap - 1;
                else if (pending_cmds.size() > 0) begin
                    if (pending_cmds[0].hold && expected_results.size() != 0)
                        waiting_drain <= 1;
                    else begin
                        t_txn t;
                        t = pending_cmds.pop_front();
                        i_cmd <= t.cmd;
                        i_timer_id <= t.id;
                        i_deadline <= t.dl;
                        i_now <= t.now;
                        start <= 1;
                    end
                end else
                    stim_done <= 1;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result id=%0d", o_fired_id);
                errors++;
            end else begin
                t_res e;
                e = expected_results.pop_front();
                if (o_item_valid !== e.item_valid) begin
                    $error("item_valid exp %0h got %0h", e.item_valid, o_item_valid); errors++; end
                if (o_fired_id !== e.fired_id) begin
                    $error("fired_id exp %0d got %0d", e.fired_id, o_fired_id); errors++; end
                if (o_callback_count !== e.cnt) begin
                    $error("callback_count exp %0d got %0d", e.cnt, o_callback_count); errors++; end
                if (o_new_earliest !== e.new_earliest) begin
                    $error("new_earliest exp %0h got %0h", e.new_earliest, o_new_earliest);
                    errors++;
                end
                if (o_earliest_valid !== e.e_valid) begin
                    $error("earliest_valid exp %0h got %0h", e.e_valid, o_earliest_valid);
                    errors++;
                end
                if (o_earliest_deadline !== e.e_dl) begin
                    $error("earliest_deadline exp %0h got %0h", e.e_dl, o_earliest_deadline);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0h got %0h", e.status, o_status); errors++; end
                if (o_last !== e.last) begin
                    $error("last exp %0h got %0h", e.last, o_last); errors++; end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void add_cmd(int c, int id, logic [63:0] dl, logic [63:0] now,
                                    bit hold = 0);
        t_txn t;
        t.cmd = 2'(c); t.id = 5'(id); t.dl = dl; t.now = now; t.hold = hold;
        pending_cmds = {pending_cmds, t};
    endfunction

    // Stimulus and end of run
    initial begin
        int c;
        logic [63:0] base;
        for (int i = 0; i < NT; i++) begin
            pos_of[i] = NT;
            cb_cnt[i] = 0;
        end
        // Directed: empty expire, cancel nothing, extremes, ties, unused command
        add_cmd(CMD_EXPIRE, 0, 0, '1);
        add_cmd(CMD_CANCEL, 31, 0, 0);
        add_cmd(CMD_ENQ, 0, '1, 0);
        add_cmd(CMD_ENQ, 31, 0, 0);
        add_cmd(CMD_ENQ, 5, 100, 0);
        add_cmd(CMD_ENQ, 6, 100, 0);
        add_cmd(CMD_ENQ, 7, 100, 0);
        add_cmd(CMD_ENQ, 5, 3, 0);
        add_cmd(CMD_UNUSED, 21, rand64(), rand64());
        add_cmd(CMD_CANCEL, 6, 0, 0);
        add_cmd(CMD_CANCEL, 6, 0, 0);
        add_cmd(CMD_EXPIRE, 0, 0, 99);
        add_cmd(CMD_EXPIRE, 0, 0, 100);
        add_cmd(CMD_EXPIRE, 0, 0, '1, 1);
        // Saturate one handle's callback count, then cancel it
        for (int i = 0; i < MAXCB + 1; i++) add_cmd(CMD_ENQ, 9, 50, 0);
        add_cmd(CMD_CANCEL, 9, 0, 0, 1);
        // Fill all handles, then expire all 32 at once
        for (int i = 0; i < NT; i++) add_cmd(CMD_ENQ, i, $urandom_range(0, 40), 0);
        add_cmd(CMD_EXPIRE, 0, 0, 64'd40, 1);
        // Random: mostly small deadlines around a moving time base for collisions
        base = 0;
        for (int n = 0; n < 12; n++) begin
            c = $urandom_range(0, 9);
            if (c < 5)
                add_cmd(CMD_ENQ, $urandom_range(0, NT-1),
                        ($urandom_range(0, 15) == 0) ? rand64() : base + $urandom_range(0, 60),
                        rand64());
            else if (c < 7)
                add_cmd(CMD_CANCEL, $urandom_range(0, NT-1), rand64(), rand64());
            else if (c < 9) begin
                base = base + $urandom_range(0, 30);
                add_cmd(CMD_EXPIRE, $urandom_range(0, NT-1), rand64(),
                        ($urandom_range(0, 20) == 0) ? rand64() : base, n == 6);
            end else
                add_cmd(CMD_UNUSED, $urandom_range(0, NT-1), rand64(), rand64());
        end
        add_cmd(CMD_EXPIRE, 0, 0, '1);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        wait (stim_done && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Timeout
    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end
endmodule
